// ===== rtl/lb64_pkg.sv =====
`default_nettype none
package lb64_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

  typedef struct packed {
    logic [23:0] triple;
    logic [15:0] base_idx;
    logic [1:0]  nbytes;
  } group_t;

endpackage
`default_nettype wire

// ===== rtl/lb64_front.sv =====
`default_nettype none
module lb64_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [15:0]       cfg_wdata,
  input  wire logic              acc_en,
  input  wire logic [7:0]        char_code,
  input  wire logic              end_of_message,
  output logic                   push,
  output lb64_pkg::group_t       push_data
);

  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
  localparam logic [7:0] CHAR_D0    = 8'h30;
  localparam logic [7:0] CHAR_D9    = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [5:0] OFS_LOWER  = 6'd26;
  localparam logic [5:0] OFS_DIGIT  = 6'd52;
  localparam logic [5:0] VAL_PLUS   = 6'd62;
  localparam logic [5:0] VAL_SLASH  = 6'd63;

  typedef struct packed {
    logic       skip;
    logic       pad;
    logic [5:0] val;
  } sextet_t;

  function automatic sextet_t classify(input logic [7:0] c);
    sextet_t s;
    s = '{skip: 1'b0, pad: 1'b0, val: 6'd0};
    if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      s.val = 6'(c - CHAR_UP_A);
    end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
      s.val = 6'(c - CHAR_LO_A) + OFS_LOWER;
    end else if (c >= CHAR_D0 && c <= CHAR_D9) begin
      s.val = 6'(c - CHAR_D0) + OFS_DIGIT;
    end else if (c == CHAR_PLUS) begin
      s.val = VAL_PLUS;
    end else if (c == CHAR_SLASH) begin
      s.val = VAL_SLASH;
    end else if (c == CHAR_PAD) begin
      s.pad = 1'b1;
    end else begin
      s.skip = 1'b1;
    end
    return s;
  endfunction

  logic [15:0] limit_r;
  logic [17:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [2:0]  pad_r, pad_nxt;
  logic [15:0] ocnt_r, ocnt_nxt;

  sextet_t     cls;
  logic [2:0]  pad_new;
  logic [1:0]  nb;
  logic [15:0] rem;
  logic [1:0]  nout;
  logic        complete;

  always_comb begin
    cls      = classify(char_code);
    pad_new  = (cls.pad && pad_r != 3'd7) ? pad_r + 3'd1 : pad_r;
    case (pad_new)
      3'd0:    nb = 2'd3;
      3'd1:    nb = 2'd2;
      default: nb = 2'd1;
    endcase
    rem      = limit_r - ocnt_r;
    if (ocnt_r >= limit_r) begin
      nout = 2'd0;
    end else if (rem < {14'd0, nb}) begin
      nout = rem[1:0];
    end else begin
      nout = nb;
    end
    complete = acc_en && !cls.skip && cnt_r == 2'd3;

    push               = complete && nout != 2'd0;
    push_data.triple   = {acc_r, cls.val};
    push_data.base_idx = ocnt_r;
    push_data.nbytes   = nout;

    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    pad_nxt  = pad_r;
    ocnt_nxt = ocnt_r;
    if (acc_en && !cls.skip) begin
      if (cnt_r != 2'd3) begin
        acc_nxt = {acc_r[11:0], cls.val};
        cnt_nxt = cnt_r + 2'd1;
        pad_nxt = pad_new;
      end else begin
        acc_nxt  = '0;
        cnt_nxt  = '0;
        pad_nxt  = '0;
        ocnt_nxt = ocnt_r + {14'd0, nout};
      end
    end
    if (acc_en && end_of_message) begin
      acc_nxt  = '0;
      cnt_nxt  = '0;
      pad_nxt  = '0;
      ocnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= lb64_pkg::LIMIT_RESET;
      acc_r   <= '0;
      cnt_r   <= '0;
      pad_r   <= '0;
      ocnt_r  <= '0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      pad_r  <= pad_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lb64_fifo.sv =====
`default_nettype none
module lb64_fifo #(
  parameter int DEPTH = lb64_pkg::FIFO_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire lb64_pkg::group_t  wdata,
  output logic                   full,
  input  wire logic              pop,
  output lb64_pkg::group_t       rdata,
  output logic                   not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  lb64_pkg::group_t mem_r [DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] cnt_r;

  assign full      = cnt_r == CNT_FULL;
  assign not_empty = cnt_r != '0;
  assign rdata     = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PTR_LAST) ? '0 : wptr_r + PW'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == PTR_LAST) ? '0 : rptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lb64_back.sv =====
`default_nettype none
module lb64_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              grp_vld,
  input  wire lb64_pkg::group_t  grp,
  output logic                   pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [7:0]             data_byte,
  output logic [15:0]            byte_index,
  output logic                   last_of_group
);

  lb64_pkg::group_t cur_r;
  logic             vld_r;
  logic [1:0]       k_r;
  logic             out_acc;

  always_comb begin
    case (k_r)
      2'd0:    data_byte = cur_r.triple[23:16];
      2'd1:    data_byte = cur_r.triple[15:8];
      default: data_byte = cur_r.triple[7:0];
    endcase
    byte_index    = cur_r.base_idx + {14'd0, k_r};
    last_of_group = k_r == cur_r.nbytes - 2'd1;
    out_tvalid    = vld_r;
    out_acc       = vld_r && out_tready;
    pop           = grp_vld && (!vld_r || (out_acc && last_of_group));
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      k_r   <= '0;
    end else begin
      if (pop) begin
        vld_r <= 1'b1;
        k_r   <= '0;
      end else if (out_acc && last_of_group) begin
        vld_r <= 1'b0;
        k_r   <= '0;
      end else if (out_acc) begin
        k_r <= k_r + 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lenient_base64_stream_decoder.sv =====
// A completing character's group is queued, then loaded into the serializer's register
// before its first byte is offered. Throughput: one character per cycle while in_tready
// is high; decoded bytes leave at one per cycle. The group queue between decoder and byte
// serializer absorbs output stalls; in_tready drops only when the queue is full.
// Reset: synchronous, active low; clears group state and queue, output_limit to 65535.
`default_nettype none
module lenient_base64_stream_decoder #(
  parameter int FIFO_DEPTH = lb64_pkg::FIFO_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tlast,   // end_of_message
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] data_byte, [23:8] byte_index
  output logic             out_tlast   // last_of_group
);

  logic             acc_en;
  logic             push;
  lb64_pkg::group_t push_data;
  logic             full;
  logic             pop;
  lb64_pkg::group_t head;
  logic             head_vld;
  logic [7:0]       data_byte;
  logic [15:0]      byte_index;

  assign in_tready = !full;
  assign acc_en    = in_tvalid && in_tready;
  assign out_tdata = {byte_index, data_byte};

  lb64_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .acc_en         (acc_en),
    .char_code      (in_tdata),
    .end_of_message (in_tlast),
    .push           (push),
    .push_data      (push_data)
  );

  lb64_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wdata     (push_data),
    .full      (full),
    .pop       (pop),
    .rdata     (head),
    .not_empty (head_vld)
  );

  lb64_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .grp_vld       (head_vld),
    .grp           (head),
    .pop           (pop),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .data_byte     (data_byte),
    .byte_index    (byte_index),
    .last_of_group (out_tlast)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("group queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_vld) else $error("group queue underflow");

  a_group_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tvalid && byte_index == $past(byte_index) + 16'd1))
    else $error("group ended without last word");

endmodule
`default_nettype wire

// ===== tb/lb64_decode_checker.sv =====
`timescale 1ns / 100ps
module lb64_decode_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // end_of_message
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [7:0] data_byte, [23:8] byte_index
  input  logic        out_tlast,  // last_of_group
  output int          error_count,
  output int          bytes_pending
);

  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] pos;
    logic        last;
  } decoded_byte_t;

  logic [17:0]   sextets;
  logic [1:0]    held;
  logic [2:0]    pads;
  logic [15:0]   delivered;
  logic [15:0]   byte_limit;
  decoded_byte_t expected_bytes[$];
  decoded_byte_t want;

  initial begin
    error_count = 0;
    bytes_pending = 0;
  end

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endfunction

  function automatic void decode_char(input logic [7:0] c, input logic eom);
    logic [5:0]    value;
    logic          keep;
    logic          is_pad;
    logic [23:0]   triple;
    int            nbytes;
    int            k;
    decoded_byte_t item;
    keep = 1'b1;
    is_pad = 1'b0;
    value = '0;
    if (c >= "A" && c <= "Z") begin
      value = 6'(c - "A");
    end else if (c >= "a" && c <= "z") begin
      value = 6'(c - "a" + 26);
    end else if (c >= "0" && c <= "9") begin
      value = 6'(c - "0" + 52);
    end else if (c == "+") begin
      value = 6'd62;
    end else if (c == "/") begin
      value = 6'd63;
    end else if (c == "=") begin
      is_pad = 1'b1;
    end else begin
      keep = 1'b0;
    end
    if (keep) begin
      if (is_pad && pads < 3'd7) begin
        pads++;
      end
      if (held < 2'd3) begin
        sextets = {sextets[11:0], value};
        held++;
      end else begin
        triple = {sextets, value};
        nbytes = (pads > 3'd2) ? 1 : 3 - int'(pads);
        for (k = 0; k < nbytes && delivered < byte_limit; k++) begin
          item.data = triple[23 - 8 * k -: 8];
          item.pos = delivered;
          item.last = (k == nbytes - 1) || (int'(delivered) + 1 >= int'(byte_limit));
          expected_bytes.push_back(item);
          delivered++;
        end
        sextets = '0;
        held = '0;
        pads = '0;
      end
    end
    if (eom) begin
      sextets = '0;
      held = '0;
      pads = '0;
      delivered = '0;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      sextets = '0;
      held = '0;
      pads = '0;
      delivered = '0;
      byte_limit = lb64_pkg::LIMIT_RESET;
      expected_bytes.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          note_error($sformatf("unexpected byte %h pos %0d last %b",
                               out_tdata[7:0], out_tdata[23:8], out_tlast));
        end else begin
          want = expected_bytes.pop_front();
          if (out_tdata[7:0] !== want.data || out_tdata[23:8] !== want.pos ||
              out_tlast !== want.last) begin
            note_error($sformatf("expected data %h pos %0d last %b, got data %h pos %0d last %b",
                                 want.data, want.pos, want.last,
                                 out_tdata[7:0], out_tdata[23:8], out_tlast));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        decode_char(in_tdata, in_tlast);
      end
      if (cfg_we) begin
        byte_limit = cfg_wdata;
      end
    end
    bytes_pending = expected_bytes.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
module tb;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 8;
  localparam int WORDS_PER_PHASE = 36;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_PAD = 8'h3D;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] char_code
  logic        in_tlast = 1'b0; // end_of_message
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [7:0] data_byte, [23:8] byte_index
  logic        out_tlast;       // last_of_group
  int          error_count;
  int          bytes_pending;
  int          cycles = 0;
  int          words_sent = 0;
  int          stall_left = 0;
  logic        calm = 1'b0;

  lenient_base64_stream_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  lb64_decode_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .error_count   (error_count),
    .bytes_pending (bytes_pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [7:0] b64_char(input int v);
    if (v < 26) begin
      return 8'("A" + v);
    end else if (v < 52) begin
      return 8'("a" + v - 26);
    end else if (v < 62) begin
      return 8'("0" + v - 52);
    end else if (v == 62) begin
      return "+";
    end
    return "/";
  endfunction

  // hold the output side off in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else begin
      out_tready = 1'b1;
      stall_left = idle_len();
    end
  end

  task automatic send_word(input logic [7:0] ch, input logic eom);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = ch;
    in_tlast = eom;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic send_text(input string s, input logic eom_last);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_word(s[i], eom_last && i == s.len() - 1);
    end
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (bytes_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_limit(input logic [15:0] limit);
    wait_drained();
    cfg_we = 1'b1;
    cfg_wdata = limit;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_random_message();
    logic [7:0] chars[$];
    int         groups;
    int         len;
    int         pads;
    int         mode;
    int         g;
    int         i;
    logic       pad;
    logic       ends;
    groups = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
    for (g = 0; g < groups; g++) begin
      mode = $urandom_range(0, 19);
      len = (mode < 2) ? $urandom_range(1, 3) : 4;
      pads = (mode >= 4 && mode < 8) ? $urandom_range(1, 2) : 0;
      for (i = 0; i < len; i++) begin
        if ($urandom_range(0, 99) < 8) begin
          case ($urandom_range(0, 3))
            0: chars.push_back(CH_SPACE);
            1: chars.push_back(CH_TAB);
            2: chars.push_back(CH_CR);
            default: chars.push_back(CH_LF);
          endcase
        end
        if ($urandom_range(0, 99) < 4) begin
          chars.push_back(8'($urandom_range(0, 255)));
        end
        pad = (mode >= 2 && mode < 4) ? 1'($urandom_range(0, 1)) : (i >= 4 - pads);
        chars.push_back(pad ? CH_PAD : b64_char($urandom_range(0, 63)));
      end
    end
    ends = ($urandom_range(0, 99) < 85);
    for (i = 0; i < chars.size(); i++) begin
      send_word(chars[i], ends && i == chars.size() - 1);
    end
  endtask

  initial begin
    int          phase;
    int          target;
    logic [15:0] limit;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_text("//9z", 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(CH_SPACE, 1'b0);
    send_word(CH_LF, 1'b0);
    send_text("A=A=", 1'b0);
    send_text("====", 1'b0);
    send_text("QU", 1'b1);
    set_limit(16'hFFFF);
    send_text("TWFuTWFu", 1'b0);

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: limit = 16'd2;
        1: limit = 16'd0;
        2: limit = 16'd1;
        3: limit = 16'd5;
        4: limit = 16'($urandom_range(3, 40));
        5: limit = 16'hFFFF;
        6: limit = 16'($urandom_range(0, 65535));
        default: limit = 16'd3;
      endcase
      set_limit(limit);
      calm = (phase == 3 || phase == 5);
      target = words_sent + WORDS_PER_PHASE;
      while (words_sent < target) send_random_message();
    end
    calm = 1'b0;

    wait_drained();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lb64_pkg.sv
rtl/lb64_front.sv
rtl/lb64_fifo.sv
rtl/lb64_back.sv
rtl/lenient_base64_stream_decoder.sv
tb/lb64_decode_checker.sv
tb/tb.sv
